// ===== rtl/dsv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsv_pkg: shared types and constants of the delimited text field splitter
// Character codes, quote modes, result kinds and the result and decode types.
// ----------------------------------------------------------------------------
package dsv_pkg;

   // character codes
   localparam logic [7:0] QUOTE_CHR   = 8'd34;
   localparam logic [7:0] COMMA_CHR   = 8'd44;
   localparam logic [7:0] NEWLINE_CHR = 8'd10;

   // quote modes
   localparam logic [1:0] MODE_OUTSIDE = 2'd0;
   localparam logic [1:0] MODE_QUOTED  = 2'd1;
   localparam logic [1:0] MODE_PENDING = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_DATA      = 2'd0;
   localparam logic [1:0] KIND_FIELD_END = 2'd1;
   localparam logic [1:0] KIND_ROW_END   = 2'd2;

   // reset value of the delimiter register
   localparam logic [7:0] DELIMITER_RESET = COMMA_CHR;

   // one result word
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
   } result_type;

   // everything one input byte produces
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
      logic [1:0] next_mode;
   } decode_type;

endpackage

// ===== rtl/dsv_field_splitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsv_field_splitter: splits delimited text into fields and rows
// A byte's first result word goes through the input register and then the
// result register; a result port stall can hold the byte in the input register.
// Throughput: one byte per cycle while bytes give at most one word and the result
// port is free; a two-word byte holds the input until its second word moves up.
// Reset (synchronous, active high): quote mode outside, delimiter comma,
// all word registers empty.
// ----------------------------------------------------------------------------
module dsv_field_splitter
   import dsv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_source,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run
);

   logic [7:0] delimiter_ff;
   logic [1:0] quote_mode_ff;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eos_ff;
   logic       in_take;
   logic       req_take;
   decode_type decode;
   result_type rsp_word;

   // input register accepts a word whenever it is empty or retiring
   assign req_stall = in_valid_ff && !in_take;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_take) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         quote_mode_ff <= MODE_OUTSIDE;
         delimiter_ff  <= DELIMITER_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         if (in_take) begin
            quote_mode_ff <= decode.next_mode;
         end
         if (csr_write_enable) begin
            delimiter_ff <= csr_write_data;
         end
      end
   end

   // input payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_in_byte;
         in_eos_ff  <= req_end_of_source;
      end
   end

   // byte decision
   dsv_decode u_decode (
      .in_byte       (in_byte_ff),
      .end_of_source (in_eos_ff),
      .quote_mode    (quote_mode_ff),
      .delimiter     (delimiter_ff),
      .decode        (decode)
   );

   // result words
   dsv_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .decode    (decode),
      .in_take   (in_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   assign rsp_kind        = rsp_word.kind;
   assign rsp_out_byte    = rsp_word.data;
   assign rsp_last_of_run = rsp_word.last;

endmodule

// ===== rtl/dsv_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsv_decode: per-byte field and row decision
// Maps one byte, its end flag, the quote mode and the delimiter to up to two
// result words and the next quote mode.
// ----------------------------------------------------------------------------
module dsv_decode
   import dsv_pkg::*;
(
   input  logic [7:0] in_byte,
   input  logic       end_of_source,
   input  logic [1:0] quote_mode,
   input  logic [7:0] delimiter,
   output decode_type decode
);

   logic [7:0] delim;
   logic [1:0] mode;
   logic       main_emit;
   logic [1:0] main_kind;
   logic [7:0] main_data;
   logic       row_closed;
   logic       eos_emit;
   result_type main_res;
   result_type eos_res;

   // quote as delimiter acts as a comma, unused mode acts as outside
   assign delim = (delimiter == QUOTE_CHR) ? COMMA_CHR : delimiter;

   // main byte handling
   always_comb begin
      mode       = (quote_mode == MODE_PENDING || quote_mode == MODE_QUOTED) ?
                   quote_mode : MODE_OUTSIDE;
      main_emit  = 1'b0;
      main_kind  = KIND_DATA;
      main_data  = 8'd0;
      row_closed = 1'b0;
      if (mode == MODE_PENDING && in_byte == QUOTE_CHR) begin
         // doubled quote gives one literal quote
         main_emit = 1'b1;
         main_data = QUOTE_CHR;
         mode      = MODE_QUOTED;
      end else begin
         if (mode == MODE_PENDING) begin
            mode = MODE_OUTSIDE;
         end
         if (mode == MODE_QUOTED) begin
            if (in_byte == QUOTE_CHR) begin
               mode = end_of_source ? MODE_OUTSIDE : MODE_PENDING;
            end else begin
               main_emit = 1'b1;
               main_data = in_byte;
            end
         end else begin
            priority if (in_byte == QUOTE_CHR) begin
               mode = MODE_QUOTED;
            end else if (in_byte == NEWLINE_CHR) begin
               main_emit  = 1'b1;
               main_kind  = KIND_ROW_END;
               row_closed = 1'b1;
            end else if (in_byte == delim) begin
               main_emit = 1'b1;
               main_kind = KIND_FIELD_END;
            end else begin
               main_emit = 1'b1;
               main_data = in_byte;
            end
         end
      end
      if (end_of_source) begin
         mode = MODE_OUTSIDE;
      end
   end

   // closing row at end of source
   assign eos_emit = end_of_source && !row_closed;

   assign main_res = '{kind: main_kind, data: main_data, last: !eos_emit};
   assign eos_res  = '{kind: KIND_ROW_END, data: 8'd0, last: 1'b1};

   // pack results in order
   always_comb begin
      decode.count     = {1'b0, main_emit} + {1'b0, eos_emit};
      decode.first     = main_emit ? main_res : eos_res;
      decode.second    = eos_res;
      decode.next_mode = mode;
   end

endmodule

// ===== rtl/dsv_out_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsv_out_queue: result register with one overflow slot
// Holds the word on the result port and the second word of a byte that
// produced two; tells the input stage when a decoded byte may be retired.
// ----------------------------------------------------------------------------
module dsv_out_queue
   import dsv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  decode_type decode,
   output logic       in_take,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp_word
);

   logic       out_valid_ff, out_valid_in;
   result_type out_word_ff, out_word_in;
   logic       pend_valid_ff, pend_valid_in;
   result_type pend_word_ff, pend_word_in;
   logic       out_taken;
   logic       out_free;

   assign out_taken = out_valid_ff && !rsp_stall;
   assign out_free  = !out_valid_ff || out_taken;

   // retire a byte when its words fit
   assign in_take = in_valid && !pend_valid_ff && (out_free || decode.count == 2'd0);

   // next state of the two slots
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      pend_valid_in = pend_valid_ff;
      pend_word_in  = pend_word_ff;
      if (out_taken) begin
         out_valid_in = 1'b0;
      end
      if (pend_valid_ff) begin
         if (out_taken) begin
            out_valid_in  = 1'b1;
            out_word_in   = pend_word_ff;
            pend_valid_in = 1'b0;
         end
      end else if (in_take && decode.count != 2'd0) begin
         out_valid_in = 1'b1;
         out_word_in  = decode.first;
         if (decode.count == 2'd2) begin
            pend_valid_in = 1'b1;
            pend_word_in  = decode.second;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      pend_word_ff <= pend_word_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule

// ===== tb/sv/tb_dsv_field_splitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dsv_field_splitter: self-checking bench for the delimited text splitter
// Bytes go in through a randomly paced driver. Each accepted byte runs through
// a local field splitting model that queues the words it should produce. A
// monitor under random stall compares every output word with the oldest queued
// one. The run steps through several delimiter settings, writing the register
// only while the block is drained.
// ----------------------------------------------------------------------------
module tb_dsv_field_splitter;
   import dsv_pkg::*;

   typedef struct packed {
      logic [7:0] value;
      logic       eos;
   } text_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic [7:0] csr_write_data = 8'd0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'd0;
   logic       req_end_of_source = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_of_run;

   text_byte_type pending_bytes[$];
   result_type    expected_words[$];
   logic [7:0] delim_setting = DELIMITER_RESET;
   logic [1:0] quote_state = MODE_OUTSIDE;
   int         failures = 0;
   int         send_gap = 0;
   int         stall_left = 0;
   bit         send_calm = 1'b0;
   bit         recv_calm = 1'b0;

   dsv_field_splitter dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_source (req_end_of_source),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   // clock, 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic result_type make_word(input logic [1:0] kind, input logic [7:0] data);
      result_type w;
      w.kind = kind;
      w.data = data;
      w.last = 1'b0;
      return w;
   endfunction

   // mostly short gaps, a few long ones, none while calm
   function automatic int pick_gap(input bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   // field splitting model: one byte in, its words onto the expected queue
   task automatic split_byte(input logic [7:0] value, input logic eos);
      logic [7:0] sep;
      logic [1:0] m;
      logic       taken;
      logic       row_done;
      result_type run[$];
      sep = (delim_setting == QUOTE_CHR) ? COMMA_CHR : delim_setting;
      m = quote_state;
      taken = 1'b0;
      row_done = 1'b0;
      // quote pending inside a quoted section
      if (m == MODE_PENDING) begin
         if (value == QUOTE_CHR) begin
            run = {run, make_word(KIND_DATA, QUOTE_CHR)};
            m = MODE_QUOTED;
            taken = 1'b1;
         end else begin
            m = MODE_OUTSIDE;
         end
      end
      if (!taken) begin
         if (m == MODE_QUOTED) begin
            if (value == QUOTE_CHR) m = eos ? MODE_OUTSIDE : MODE_PENDING;
            else run = {run, make_word(KIND_DATA, value)};
         end else if (value == QUOTE_CHR) begin
            m = MODE_QUOTED;
         end else if (value == NEWLINE_CHR) begin
            run = {run, make_word(KIND_ROW_END, 8'd0)};
            row_done = 1'b1;
         end else if (value == sep) begin
            run = {run, make_word(KIND_FIELD_END, 8'd0)};
         end else begin
            run = {run, make_word(KIND_DATA, value)};
         end
      end
      // end of source closes the open row
      if (eos) begin
         if (!row_done) run = {run, make_word(KIND_ROW_END, 8'd0)};
         m = MODE_OUTSIDE;
      end
      quote_state = m;
      if (run.size() > 0) run[run.size() - 1].last = 1'b1;
      foreach (run[i]) expected_words = {expected_words, run[i]};
   endtask

   // byte driver
   always @(posedge clock) begin : driver
      text_byte_type next_byte;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            split_byte(req_in_byte, req_end_of_source);
            if ($urandom_range(0, 149) == 0) send_calm = !send_calm;
            send_gap = pick_gap(send_calm);
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               next_byte = pending_bytes.pop_front();
               req_valid <= 1'b1;
               req_in_byte <= next_byte.value;
               req_end_of_source <= next_byte.eos;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // word monitor and receiver stall
   always @(posedge clock) begin : monitor
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word kind %0d byte %02h last %0b", $time,
                        rsp_kind, rsp_out_byte, rsp_last_of_run);
               failures++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_kind !== want.kind) begin
                  $display("%0t: kind expected %0d actual %0d", $time, want.kind, rsp_kind);
                  failures++;
               end
               if (rsp_out_byte !== want.data) begin
                  $display("%0t: out_byte expected %02h actual %02h", $time,
                           want.data, rsp_out_byte);
                  failures++;
               end
               if (rsp_last_of_run !== want.last) begin
                  $display("%0t: last_of_run expected %0b actual %0b", $time,
                           want.last, rsp_last_of_run);
                  failures++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            if ($urandom_range(0, 149) == 0) recv_calm = !recv_calm;
            stall_left = pick_gap(recv_calm);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic add_byte(input logic [7:0] value, input logic eos);
      text_byte_type t;
      t.value = value;
      t.eos = eos;
      pending_bytes = {pending_bytes, t};
   endtask

   // wait until every byte is taken and every word has come out
   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_valid || expected_words.size() != 0)
         @(negedge clock);
      // bytes such as an opening quote give no word but may still be in flight
      repeat (8) @(negedge clock);
   endtask

   task automatic write_delimiter(input logic [7:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      delim_setting = value;
      @(negedge clock);
   endtask

   // well-formed rows with random content, mixed with raw noise
   task automatic queue_random_text(input int count);
      int         added;
      int         fields;
      int         len;
      logic [7:0] sep;
      logic [7:0] v;
      int         r;
      sep = (delim_setting == QUOTE_CHR) ? COMMA_CHR : delim_setting;
      added = pending_bytes.size();
      while (pending_bytes.size() - added < count) begin
         if ($urandom_range(0, 9) < 2) begin
            // noise burst
            repeat ($urandom_range(1, 8))
               add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
         end else begin
            fields = $urandom_range(1, 4);
            for (int f = 0; f < fields; f++) begin
               if (f > 0) add_byte(sep, 1'b0);
               len = $urandom_range(0, 5);
               if ($urandom_range(0, 2) == 0) begin
                  // quoted field, embedded quotes doubled
                  add_byte(QUOTE_CHR, 1'b0);
                  repeat (len) begin
                     v = 8'($urandom_range(0, 255));
                     add_byte(v, 1'b0);
                     if (v == QUOTE_CHR) add_byte(QUOTE_CHR, 1'b0);
                  end
                  add_byte(QUOTE_CHR, 1'b0);
               end else begin
                  repeat (len) begin
                     do v = 8'($urandom_range(0, 255));
                     while (v == QUOTE_CHR || v == NEWLINE_CHR || v == sep);
                     add_byte(v, 1'b0);
                  end
               end
            end
            // row ends in a newline, or the source ends on its last byte
            r = $urandom_range(0, 9);
            if (r < 7) add_byte(NEWLINE_CHR, 1'b0);
            else if (r == 7 || pending_bytes.size() == 0) add_byte(NEWLINE_CHR, 1'b1);
            else pending_bytes[pending_bytes.size() - 1].eos = 1'b1;
         end
      end
   endtask

   // stimulus and end of run
   initial begin
      logic [7:0] delim_plan[8];
      delim_plan = '{8'd0, 8'd255, QUOTE_CHR, NEWLINE_CHR, 8'd9, 8'd59, 8'd0, COMMA_CHR};
      delim_plan[6] = 8'($urandom_range(0, 255));
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed words under the reset delimiter
      add_byte("a", 1'b0);
      add_byte(COMMA_CHR, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(NEWLINE_CHR, 1'b0);
      // delimiter and newline inside quotes, doubled quote, pending quote then newline
      add_byte(QUOTE_CHR, 1'b0);
      add_byte(COMMA_CHR, 1'b0);
      add_byte(NEWLINE_CHR, 1'b0);
      add_byte(QUOTE_CHR, 1'b0);
      add_byte(QUOTE_CHR, 1'b0);
      add_byte("x", 1'b0);
      add_byte(QUOTE_CHR, 1'b0);
      add_byte(NEWLINE_CHR, 1'b0);
      // quote at end of source closes the section
      add_byte(QUOTE_CHR, 1'b0);
      add_byte("q", 1'b0);
      add_byte(QUOTE_CHR, 1'b1);
      // doubled quote carrying end of source
      add_byte(QUOTE_CHR, 1'b0);
      add_byte(QUOTE_CHR, 1'b0);
      add_byte(QUOTE_CHR, 1'b1);
      // end of source on data, newline, opening quote and delimiter
      add_byte("z", 1'b1);
      add_byte(NEWLINE_CHR, 1'b1);
      add_byte(QUOTE_CHR, 1'b1);
      add_byte(COMMA_CHR, 1'b1);
      queue_random_text(180);
      wait_drained();

      foreach (delim_plan[i]) begin
         write_delimiter(delim_plan[i]);
         queue_random_text(180);
         wait_drained();
      end

      if (failures == 0)
         $display("tb_dsv_field_splitter OK");
      else
         $display("tb_dsv_field_splitter NOT OK");
      $finish;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("tb_dsv_field_splitter NOT OK");
      $finish;
   end

endmodule
